// File: design/csu_pkg.sv
// Shared types and constants for the cosine similarity unit.
`timescale 1ns / 1ps
package csu_pkg;
  localparam int unsigned AccBits = 48;
  localparam int unsigned SimBits = 16;
  localparam logic [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic [SimBits-1:0] SimOne = 16'd16384;

  // Finished accumulation handed from front to back
  typedef struct packed {
    logic [AccBits-1:0] dot;
    logic [AccBits-1:0] norm_a;
    logic [AccBits-1:0] norm_b;
    logic               sat;
  } acc_res_t;

  typedef enum logic [2:0] {
    BkIdle, BkSqrt, BkMul, BkDiv, BkOut
  } bk_state_e;
endpackage

// File: design/csu_front.sv
// Front end: accepts element pairs and keeps saturating accumulators.
`timescale 1ns / 1ps
module csu_front #(
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ELEM_BITS-1:0]   elem_a_i,
  input  logic [ELEM_BITS-1:0]   elem_b_i,
  input  logic                   last_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output csu_pkg::acc_res_t      res_o
);
  import csu_pkg::*;

  localparam int unsigned PB = 2 * ELEM_BITS;

  logic [PB-1:0] pab_q, paa_q, pbb_q;
  logic          pv_q, plast_q;
  logic signed [AccBits-1:0] dot_q;
  logic [AccBits-1:0] na_q, nb_q;
  logic sat_q;
  logic hold_q;
  acc_res_t res_q;

  logic signed [AccBits+1:0] dsum;
  logic [AccBits:0] sa, sb;
  logic signed [AccBits-1:0] dot_d;
  logic [AccBits-1:0] na_d, nb_d;
  logic sat_d;
  logic signed [ELEM_BITS-1:0] ea, eb;

  assign ea = elem_a_i;
  assign eb = elem_b_i;
  // stall only when a finished vector waits and the pipe holds another last
  assign in_ready_o = !(hold_q && pv_q && plast_q);
  assign res_valid_o = hold_q;
  assign res_o = res_q;

  always_comb begin
    dsum = {{2{dot_q[AccBits-1]}}, dot_q} +
           {{(AccBits+2-PB){pab_q[PB-1]}}, pab_q};
    sa = {1'b0, na_q} + {{(AccBits+1-PB){1'b0}}, paa_q};
    sb = {1'b0, nb_q} + {{(AccBits+1-PB){1'b0}}, pbb_q};
    sat_d = sat_q;
    if (dsum > $signed({2'b00, AccMax})) begin
      dot_d = $signed(AccMax);
      sat_d = 1'b1;
    end else if (dsum < -$signed({2'b00, AccMax}) - 1) begin
      dot_d = $signed(~AccMax);
      sat_d = 1'b1;
    end else begin
      dot_d = dsum[AccBits-1:0];
    end
    if (sa > {1'b0, AccMax}) begin
      na_d = AccMax;
      sat_d = 1'b1;
    end else begin
      na_d = sa[AccBits-1:0];
    end
    if (sb > {1'b0, AccMax}) begin
      nb_d = AccMax;
      sat_d = 1'b1;
    end else begin
      nb_d = sb[AccBits-1:0];
    end
  end

  // products stage, one register after the multipliers; holds while stalled
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      pab_q <= PB'(ea * eb);
      paa_q <= PB'(ea * ea);
      pbb_q <= PB'(eb * eb);
      plast_q <= last_i;
    end
  end

  logic fire;
  assign fire = pv_q && !(plast_q && hold_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      dot_q  <= '0;
      na_q   <= '0;
      nb_q   <= '0;
      sat_q  <= 1'b0;
      hold_q <= 1'b0;
      res_q  <= '0;
    end else begin
      if (hold_q && res_ready_i) hold_q <= 1'b0;
      if (in_ready_o) pv_q <= in_valid_i;
      if (fire) begin
        if (plast_q) begin
          res_q  <= '{dot: dot_d, norm_a: na_d, norm_b: nb_d, sat: sat_d};
          hold_q <= 1'b1;
          dot_q  <= '0;
          na_q   <= '0;
          nb_q   <= '0;
          sat_q  <= 1'b0;
        end else begin
          dot_q <= dot_d;
          na_q  <= na_d;
          nb_q  <= nb_d;
          sat_q <= sat_d;
        end
      end
    end
  end
endmodule

// File: design/csu_back.sv
// Back end: square roots, product, divide and rounding of one vector result.
`timescale 1ns / 1ps
module csu_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      res_valid_i,
  output logic                      res_ready_o,
  input  csu_pkg::acc_res_t         res_i,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,
  output logic                      m_axis_tuser
);
  import csu_pkg::*;

  localparam int unsigned RadBits = AccBits + 16;  // 64
  localparam int unsigned RootBits = RadBits / 2;  // 32
  localparam int unsigned DenBits = 2 * RootBits;

  bk_state_e state_q, state_d;
  logic [5:0] cnt_q;
  logic [RadBits-1:0] xa_q, xb_q, ra_q, rb_q, ba_q;
  logic [DenBits-1:0] den_q;
  logic [DenBits:0] rem_q;
  logic [31:0] quo_q;
  logic [AccBits-1:0] num_q;
  logic neg_q, zn_q, sat_q;
  logic [1:0] mstep_q;
  logic [DenBits-1:0] pp_q;
  logic [SimBits-1:0] sim;
  logic ov_q;

  logic [RadBits-1:0] ta, tb;
  logic [DenBits:0] rsh;
  logic [31:0] qinc;

  always_comb begin
    ta = ra_q + ba_q;
    tb = rb_q + ba_q;
    rsh = {rem_q[DenBits-1:0], 1'b0};
    qinc = quo_q + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BkIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    res_ready_o = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      BkIdle: begin
        res_ready_o = 1'b1;
        if (res_valid_i) state_d = BkSqrt;
      end
      BkSqrt: if (cnt_q == 6'd31) state_d = zn_q ? BkOut : BkMul;
      BkMul: if (mstep_q == 2'd3) state_d = BkDiv;
      BkDiv: if (ov_q || cnt_q == 6'd30) state_d = BkOut;
      BkOut: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_d = BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  logic [SimBits-1:0] mag;
  always_comb begin
    if (zn_q) mag = '0;
    else if (ov_q) mag = SimOne;
    else if (qinc[31:1] > {15'd0, SimOne}) mag = SimOne;
    else mag = qinc[SimBits:1];
    sim = neg_q ? SimBits'(-mag) : mag;
  end
  assign m_axis_tdata = {6'd0, sat_q, zn_q, sim};
  assign m_axis_tuser = 1'b0;

  // datapath: two digit-by-digit roots, two 32x16 partial products, divider
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BkIdle: begin
        xa_q  <= {res_i.norm_a, 16'd0};
        xb_q  <= {res_i.norm_b, 16'd0};
        ra_q  <= '0;
        rb_q  <= '0;
        ba_q  <= {2'b01, {(RadBits-2){1'b0}}};
        cnt_q <= '0;
        zn_q  <= (res_i.norm_a == '0) || (res_i.norm_b == '0);
        sat_q <= res_i.sat;
        neg_q <= res_i.dot[AccBits-1];
        num_q <= res_i.dot[AccBits-1] ? AccBits'(-res_i.dot) : res_i.dot;
        mstep_q <= '0;
        ov_q  <= 1'b0;
      end
      BkSqrt: begin
        if (xa_q >= ta) begin
          xa_q <= xa_q - ta;
          ra_q <= (ra_q >> 1) + ba_q;
        end else ra_q <= ra_q >> 1;
        if (xb_q >= tb) begin
          xb_q <= xb_q - tb;
          rb_q <= (rb_q >> 1) + ba_q;
        end else rb_q <= rb_q >> 1;
        ba_q  <= ba_q >> 2;
        cnt_q <= cnt_q + 6'd1;
        den_q <= '0;
      end
      BkMul: begin
        // one 32x16 slice of the root product per cycle
        pp_q <= DenBits'(ra_q[RootBits-1:0] *
                rb_q[16*mstep_q[0] +: 16]);
        if (mstep_q == 2'd1) den_q <= pp_q;
        if (mstep_q == 2'd2) den_q <= den_q + (pp_q << 16);
        mstep_q <= mstep_q + 2'd1;
        rem_q <= {{(DenBits+1-AccBits){1'b0}}, num_q};
        quo_q <= '0;
        cnt_q <= '0;
      end
      BkDiv: begin
        if (cnt_q == 6'd0 && !ov_q && rem_q[DenBits-1:0] >= den_q) ov_q <= 1'b1;
        else begin
          if (rsh >= {1'b0, den_q}) begin
            rem_q <= rsh - {1'b0, den_q};
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rsh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
        end
      end
      BkOut: ;
      default: ;
    endcase
  end
endmodule

// File: design/cosine_similarity_unit.sv
// Top level of the streaming cosine similarity unit.
// On the last pair the result passes 2 front stages, 32 root steps, 4
// multiply steps and 31 divide steps (fewer when the quotient overflows)
// before the result beat is valid; multiply and divide are skipped when a
// norm is zero. Throughput: one pair per cycle; a further vector end waits
// while the previous result still waits for the back end. Reset clears accumulators and control; no beat is pending.
`timescale 1ns / 1ps
module cosine_similarity_unit #(
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [2*ELEM_BITS-1:0]    s_axis_tdata,  // elem_a, elem_b
  input  logic                      s_axis_tlast,  // last
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // similarity, zero_norm, saturated
  output logic                      m_axis_tuser   // unused, zero
);
  import csu_pkg::*;

  acc_res_t res;
  logic res_valid, res_ready, back_rdy;

  csu_front #(.ELEM_BITS(ELEM_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .elem_a_i(s_axis_tdata[ELEM_BITS-1:0]),
    .elem_b_i(s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]),
    .last_i(s_axis_tlast),
    .res_valid_o(res_valid), .res_ready_i(back_rdy), .res_o(res)
  );

  assign res_ready = back_rdy;

  csu_back u_back (
    .clk_i, .rst_ni,
    .res_valid_i(res_valid && res_ready), .res_ready_o(back_rdy), .res_i(res),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );
endmodule

// File: tb/sv/tb_cosine_similarity_unit.sv
// Testbench for cosine_similarity_unit: streamed vectors checked against a predictor.
`timescale 1ns / 1ps
module tb_cosine_similarity_unit;
  import csu_pkg::*;

  localparam int unsigned ElemBits  = 16;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [15:0] sim;
    logic        zero_norm;
    logic        sat;
  } sim_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [2*ElemBits-1:0]   s_axis_tdata = '0;  // elem_a, elem_b
  logic                    s_axis_tlast = 1'b0; // last
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [23:0]             m_axis_tdata;  // similarity, zero_norm, saturated
  logic                    m_axis_tuser;

  cosine_similarity_unit #(.ELEM_BITS(ElemBits)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  // Predictor state
  logic signed [AccBits-1:0] dot_sum;
  logic [AccBits-1:0]        sq_a_sum, sq_b_sum;
  logic                      sat_flag;
  sim_res_t                  sim_q[$];
  int                        err_cnt = 0;
  int                        idle_cycles = 0;
  int                        burst_left = 0;
  bit                        long_stall = 0;

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Accumulate one pair; push the similarity when the pair ends a vector
  task automatic predict_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst);
    logic signed [63:0] d, prod;
    logic [63:0]        sa, sb, ra, rb, den, num, r, q, mag;
    sim_res_t           res;
    prod = 64'(a) * 64'(b);
    d = 64'(dot_sum) + prod;
    if (d > $signed(64'(AccMax))) begin d = 64'(AccMax); sat_flag = 1; end
    if (d < -$signed(64'(AccMax)) - 1) begin d = -$signed(64'(AccMax)) - 1; sat_flag = 1; end
    dot_sum = d[AccBits-1:0];
    sa = 64'(sq_a_sum) + 64'(64'(a) * 64'(a));
    sb = 64'(sq_b_sum) + 64'(64'(b) * 64'(b));
    if (sa > 64'(AccMax)) begin sa = 64'(AccMax); sat_flag = 1; end
    if (sb > 64'(AccMax)) begin sb = 64'(AccMax); sat_flag = 1; end
    sq_a_sum = sa[AccBits-1:0];
    sq_b_sum = sb[AccBits-1:0];
    if (!lst) return;
    mag = 0;
    res.zero_norm = (sq_a_sum == 0) || (sq_b_sum == 0);
    if (!res.zero_norm) begin
      ra = int_root(64'(sq_a_sum) << 16);
      rb = int_root(64'(sq_b_sum) << 16);
      den = ra * rb;
      num = dot_sum < 0 ? 64'(-64'(dot_sum)) : 64'(dot_sum);
      if (num >= den) begin
        mag = SimOne;
      end else begin
        r = num; q = 0;
        for (int i = 0; i < 31; i++) begin
          r <<= 1; q <<= 1;
          if (r >= den) begin r -= den; q |= 1; end
        end
        mag = (q + 1) >> 1;
        if (mag > SimOne) mag = SimOne;
      end
    end
    res.sim = dot_sum < 0 ? 16'(-mag) : 16'(mag);
    res.sat = sat_flag;
    sim_q.push_back(res);
    dot_sum = 0; sq_a_sum = 0; sq_b_sum = 0; sat_flag = 0;
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Send one beat; sender runs in bursts with random gaps
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pair(a, b, lst);
  endtask

  task automatic send_vector(int len, int shape);
    logic signed [15:0] a, b;
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom); b = 16'($urandom);
      case (shape)
        1: b = a;
        2: b = -a;
        3: begin a = 16'($urandom_range(0, 15)) - 8; b = 16'($urandom_range(0, 15)) - 8; end
        4: begin a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; b = a; end
        5: a = $urandom_range(0, 3) == 0 ? 16'h0000 : a;
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_pair(16'h7fff, 16'h7fff, 1);
    send_pair(16'h8000, 16'h8000, 1);
    send_pair(16'h8000, 16'h7fff, 1);
    send_pair(16'h0000, 16'h1234, 1);  // zero norm on a
    send_pair(16'h4000, 16'h0000, 1);  // zero norm on b
    send_pair(16'h0000, 16'h0000, 1);
    send_pair(16'h0001, 16'hffff, 1);
    send_pair(16'h5555, 16'haaaa, 0);
    send_pair(16'haaaa, 16'h5555, 1);
    send_pair(16'h0003, 16'h0004, 0);
    send_pair(16'h0004, 16'hfffd, 1);  // orthogonal
    send_pair(16'h7fff, 16'h0001, 0);
    send_pair(16'h0001, 16'h7fff, 1);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 1000) begin
      int len;
      len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 12);
      send_vector(len, $urandom_range(0, 5));
      sent += len;
    end
  endtask

  // Long full-scale vectors: the clamp to one and its sign are covered; the
  // accumulators need some 2^17 full-scale pairs to saturate, beyond this run.
  task automatic test_long();
    send_vector(300, 4);
    send_vector(200, 2);
  endtask

  // Receiver stall pattern: mostly ready, with occasional long stalls
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) long_stall <= ~long_stall;
    m_axis_tready <= long_stall ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) != 0);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sim_res_t want;
      if (sim_q.size() == 0) begin
        report("unexpected beat", m_axis_tdata[15:0], 16'h0);
      end else begin
        want = sim_q.pop_front();
        if (m_axis_tdata[15:0] !== want.sim) report("similarity", m_axis_tdata[15:0], want.sim);
        if (m_axis_tdata[16] !== want.zero_norm)
          report("zero_norm", 16'(m_axis_tdata[16]), 16'(want.zero_norm));
        if (m_axis_tdata[17] !== want.sat)
          report("saturated", 16'(m_axis_tdata[17]), 16'(want.sat));
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_cosine_similarity_unit: FAIL");
      $finish;
    end
  end

  initial begin
    dot_sum = 0; sq_a_sum = 0; sq_b_sum = 0; sat_flag = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_long();
    s_axis_tvalid <= 1'b0;
    while (sim_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_cosine_similarity_unit: PASS");
    end else begin
      $display("tb_cosine_similarity_unit: FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/csu_pkg.sv
design/csu_front.sv
design/csu_back.sv
design/cosine_similarity_unit.sv
tb/sv/tb_cosine_similarity_unit.sv
